### rtl/tts_pkg.sv
// Package for the tick task scheduler: payload types, codes and constants.
`default_nettype none

package tts_pkg;

  localparam int NumSlotsDef = 8;
  localparam int TickMsDef   = 10;
  localparam int MaxResults  = 8;
  localparam int ResCntW     = $clog2(MaxResults);
  localparam int QueueDepth  = 2;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_ADD      = 2'd1,
    KIND_DELETE   = 2'd2,
    KIND_DISPATCH = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_ADDED = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RUN   = 2'd2,
    STAT_NONE  = 2'd3
  } status_e;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  task_code;
    logic [15:0] delay_ms;
    logic [15:0] period_ms;
    logic [2:0]  slot;
  } sched_in_t;

  typedef struct packed {
    status_e    status;
    logic [2:0] slot_index;
    logic [7:0] run_code;
    logic       last;
    logic       sleep;
  } sched_out_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  task_code;
    logic [15:0] delay_ticks;
    logic [15:0] period_ticks;
    logic [2:0]  slot;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] delay_left;
    logic [15:0] reload_period;
    logic [7:0]  pending_runs;
  } slot_ent_t;

endpackage

`default_nettype wire

### rtl/tts_front.sv
// Front end: accepts input words and converts milliseconds to ticks.
`default_nettype none

module tts_front import tts_pkg::*; #(
  parameter int TICK_MS = TickMsDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire sched_in_t in_i,
  output logic           cmd_valid_o,
  input  wire logic      cmd_ready_i,
  output cmd_t           cmd_o
);

  // x / TICK_MS == (x * ceil(2^S / TICK_MS)) >> S, exact for 16-bit x
  localparam int          DivShift = 16 + $clog2(TICK_MS);
  localparam int          PW       = 16 + DivShift + 1;
  localparam logic [63:0] DivMulW  =
    ((64'd1 << DivShift) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
  localparam logic [DivShift:0] DivMul = DivMulW[DivShift:0];

  logic          st_v_q;
  kind_e         kind_q;
  logic [7:0]    code_q;
  logic [2:0]    slot_q;
  logic [PW-1:0] dly_prod_q, dly_prod_d;
  logic [PW-1:0] per_prod_q, per_prod_d;
  logic          acc;

  assign in_ready_o = !st_v_q || cmd_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  assign dly_prod_d = PW'(in_i.delay_ms) * PW'(DivMul);
  assign per_prod_d = PW'(in_i.period_ms) * PW'(DivMul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= 1'b0;
    end else if (acc) begin
      st_v_q <= 1'b1;
    end else if (cmd_ready_i) begin
      st_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      kind_q     <= in_i.kind;
      code_q     <= in_i.task_code;
      slot_q     <= in_i.slot;
      dly_prod_q <= dly_prod_d;
      per_prod_q <= per_prod_d;
    end
  end

  always_comb begin
    cmd_valid_o        = st_v_q;
    cmd_o.kind         = kind_q;
    cmd_o.task_code    = code_q;
    cmd_o.delay_ticks  = dly_prod_q[DivShift +: 16];
    cmd_o.period_ticks = per_prod_q[DivShift +: 16];
    cmd_o.slot         = slot_q;
  end

endmodule

`default_nettype wire

### rtl/tts_queue.sv
// Short command queue between front end and slot engine.
`default_nettype none

module tts_queue import tts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire cmd_t push_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_o
);

  // depth is a power of two, so pointers wrap naturally
  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            buf_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

`default_nettype wire

### rtl/tts_back.sv
// Slot engine: walks the slot table one entry a cycle while the output is not stalled, and emits result words.
`default_nettype none

module tts_back import tts_pkg::*; #(
  parameter int NUM_SLOTS = NumSlotsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  output logic      cmd_ready_o,
  input  wire cmd_t cmd_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output sched_out_t out_o
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  back_state_e          state_q, state_d;
  logic [IW-1:0]        p_idx_q, p_idx_d;
  logic [ResCntW-1:0]   cnt_q, cnt_d;
  cmd_t                 cmd_q;
  slot_ent_t            mem_q [NUM_SLOTS];
  slot_ent_t            rd_q;
  logic                 rd_vld_q;
  logic [NUM_SLOTS-1:0] valid_q, pend_nz_q;
  logic                 out_v_q;
  sched_out_t           out_q;

  slot_ent_t            ent, upd;
  sched_out_t           res;
  logic [NUM_SLOTS-1:0] idx_hot;
  logic                 out_load_ok, at_end, above_nz, others_nz;
  logic                 pop, rd_en, wr_en, wr_go, wr_keep, wr_nz;
  logic                 emit, emit_go, finish, advance, del_en;
  logic [IW-1:0]        rd_addr, del_idx;

  assign out_load_ok = !out_v_q || out_ready_i;
  assign at_end      = p_idx_q == IW'(NUM_SLOTS - 1);
  assign above_nz    = |((pend_nz_q >> p_idx_q) >> 1);
  assign others_nz   = |(pend_nz_q & ~idx_hot);
  assign ent         = rd_vld_q ? rd_q : '0;
  assign del_idx     = IW'(cmd_i.slot);
  assign wr_go       = wr_en && advance;
  assign emit_go     = emit && out_load_ok;
  assign cmd_ready_o = pop;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  always_comb begin
    idx_hot          = '0;
    idx_hot[p_idx_q] = 1'b1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (pop && rd_en) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (advance && (finish || at_end)) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    upd     = ent;
    res     = '0;
    pop     = 1'b0;
    rd_en   = 1'b0;
    rd_addr = p_idx_q + IW'(1);
    wr_en   = 1'b0;
    wr_keep = 1'b1;
    wr_nz   = 1'b0;
    emit    = 1'b0;
    finish  = 1'b0;
    advance = 1'b0;
    del_en  = 1'b0;
    p_idx_d = p_idx_q;
    cnt_d   = cnt_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == KIND_DELETE) begin
            pop    = 1'b1;
            del_en = 32'(cmd_i.slot) < NUM_SLOTS;
          end else if (cmd_i.kind == KIND_DISPATCH && pend_nz_q == '0) begin
            if (out_load_ok) begin
              pop        = 1'b1;
              emit       = 1'b1;
              res.status = STAT_NONE;
              res.last   = 1'b1;
              res.sleep  = 1'b1;
            end
          end else begin
            pop     = 1'b1;
            rd_en   = 1'b1;
            rd_addr = '0;
            p_idx_d = '0;
            cnt_d   = '0;
          end
        end
      end
      BK_SCAN: begin
        case (cmd_q.kind)
          KIND_TICK: begin
            if (ent.task_id != '0) begin
              wr_en = 1'b1;
              if (ent.delay_left == '0) begin
                if (ent.pending_runs != 8'hFF) begin
                  upd.pending_runs = ent.pending_runs + 8'd1;
                end
                if (ent.reload_period != '0) begin
                  upd.delay_left = ent.reload_period;
                end
              end else begin
                upd.delay_left = ent.delay_left - 16'd1;
              end
            end
          end
          KIND_ADD: begin
            if (ent.task_id == '0) begin
              wr_en              = 1'b1;
              upd.task_id        = cmd_q.task_code;
              upd.delay_left     = cmd_q.delay_ticks;
              upd.reload_period  = cmd_q.period_ticks;
              upd.pending_runs   = '0;
              emit               = 1'b1;
              res.status         = STAT_ADDED;
              res.slot_index     = 3'(p_idx_q);
              res.last           = 1'b1;
              finish             = 1'b1;
            end else if (at_end) begin
              emit       = 1'b1;
              res.status = STAT_FULL;
              res.last   = 1'b1;
            end
          end
          KIND_DISPATCH: begin
            if (ent.pending_runs != '0) begin
              wr_en            = 1'b1;
              upd.pending_runs = ent.pending_runs - 8'd1;
              wr_keep          = ent.reload_period != '0;
              emit             = 1'b1;
              res.status       = STAT_RUN;
              res.slot_index   = 3'(p_idx_q);
              res.run_code     = ent.task_id;
              res.last         = (cnt_q == ResCntW'(MaxResults - 1)) || !above_nz;
              res.sleep        = res.last && !others_nz &&
                                 !(wr_keep && upd.pending_runs != '0);
              finish           = res.last;
            end
          end
          default: ;
        endcase
        wr_nz   = wr_keep && upd.pending_runs != '0;
        advance = !emit || out_load_ok;
        if (advance && !finish && !at_end) begin
          rd_en   = 1'b1;
          p_idx_d = p_idx_q + IW'(1);
        end
        if (emit_go && cmd_q.kind == KIND_DISPATCH) begin
          cnt_d = cnt_q + ResCntW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      p_idx_q   <= '0;
      cnt_q     <= '0;
      valid_q   <= '0;
      pend_nz_q <= '0;
      out_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      p_idx_q <= p_idx_d;
      cnt_q   <= cnt_d;
      if (del_en) begin
        valid_q[del_idx]   <= 1'b0;
        pend_nz_q[del_idx] <= 1'b0;
      end
      if (wr_go) begin
        valid_q[p_idx_q]   <= wr_keep;
        pend_nz_q[p_idx_q] <= wr_nz;
      end
      if (emit_go) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= cmd_i;
    end
    if (emit_go) begin
      out_q <= res;
    end
    if (wr_go) begin
      mem_q[p_idx_q] <= upd;
    end
    if (rd_en) begin
      rd_q     <= mem_q[rd_addr];
      rd_vld_q <= valid_q[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/tick_task_scheduler_core.sv
// Top level of the tick task scheduler: front end, command queue, slot engine.
//
// Input channel (in_valid_i/in_ready_o/in_i) takes one word per command:
// tick, add task, delete task or dispatch. Output channel
// (out_valid_o/out_ready_i/out_o) returns result words: one for add, one per
// ready slot for dispatch (at most 8, lowest slot first, last flagged), or
// one idle word when nothing is ready. Tick and delete return nothing.
// The front end registers the ms-to-tick multiply and the queue registers the
// command; then the slot engine walks the table one slot per cycle while the
// output is not stalled. Tick and a full add walk every slot; add and dispatch
// stop early at the free slot or last ready slot. Delete and idle dispatch need no walk.
// The engine takes no new command while it walks the table, which has a single
// read port. Results leave one per cycle while the receiver is ready.
// Reset empties every slot at once through per-slot valid bits.
// When the receiver stalls, the engine holds its walk on a slot that has a
// result to emit; the queue keeps accepting commands until it is full.
`default_nettype none

module tick_task_scheduler_core import tts_pkg::*; #(
  parameter int NUM_SLOTS = NumSlotsDef,
  parameter int TICK_MS   = TickMsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire sched_in_t  in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output sched_out_t      out_o
);

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  cmd_t fq_cmd, qb_cmd;

  tts_front #(
    .TICK_MS (TICK_MS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  tts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_i       (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_o        (qb_cmd)
  );

  tts_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  a_single_word_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != STAT_RUN |-> out_o.last)
    else $error("add or idle result without last");

  a_sleep_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.sleep |-> out_o.last)
    else $error("sleep flagged on a non-final result");

  a_idle_sleeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == STAT_NONE |-> out_o.sleep)
    else $error("idle dispatch without sleep");

endmodule

`default_nettype wire

### bench/tb_tick_task_scheduler_core.sv
// Testbench for the tick task scheduler core: slot table predictor with directed and random command traffic.
`timescale 1ns / 100ps

module tb_tick_task_scheduler_core;
  import tts_pkg::*;

  localparam int NumSlots  = NumSlotsDef;
  localparam int TickMs    = TickMsDef;
  localparam int IdleLimit = 5000;
  localparam int HoldCycles = 300;

  class slot_table_model;
    bit [7:0]    code_tab   [NumSlots];
    bit [15:0]   delay_tab  [NumSlots];
    bit [15:0]   period_tab [NumSlots];
    bit [7:0]    runs_tab   [NumSlots];
    sched_out_t  due_results[$];
    int unsigned mismatches;

    function new();
      for (int s = 0; s < NumSlots; s++) begin
        clear_slot(s);
      end
      mismatches = 0;
    endfunction

    function void clear_slot(int s);
      code_tab[s]   = 8'h00;
      delay_tab[s]  = 16'h0000;
      period_tab[s] = 16'h0000;
      runs_tab[s]   = 8'h00;
    endfunction

    function sched_out_t make_word(status_e st, int idx, bit [7:0] code, bit lst, bit slp);
      sched_out_t r;
      r.status     = st;
      r.slot_index = 3'(idx);
      r.run_code   = code;
      r.last       = lst;
      r.sleep      = slp;
      return r;
    endfunction

    function void apply_command(sched_in_t w);
      sched_out_t runs_out[MaxResults];
      int         n;
      int         free_slot;
      bit         any;
      case (w.kind)
        KIND_TICK: begin
          for (int s = 0; s < NumSlots; s++) begin
            if (code_tab[s] != 8'h00) begin
              if (delay_tab[s] == 16'h0000) begin
                if (runs_tab[s] != 8'hFF) runs_tab[s] = runs_tab[s] + 8'h01;
                if (period_tab[s] != 16'h0000) delay_tab[s] = period_tab[s];
              end else begin
                delay_tab[s] = delay_tab[s] - 16'h0001;
              end
            end
          end
        end
        KIND_ADD: begin
          free_slot = -1;
          for (int s = 0; s < NumSlots; s++) begin
            if (free_slot < 0 && code_tab[s] == 8'h00) free_slot = s;
          end
          if (free_slot < 0) begin
            due_results.push_back(make_word(STAT_FULL, 0, 8'h00, 1'b1, 1'b0));
          end else begin
            code_tab[free_slot]   = w.task_code;
            delay_tab[free_slot]  = 16'(32'(w.delay_ms) / TickMs);
            period_tab[free_slot] = 16'(32'(w.period_ms) / TickMs);
            runs_tab[free_slot]   = 8'h00;
            due_results.push_back(make_word(STAT_ADDED, free_slot, 8'h00, 1'b1, 1'b0));
          end
        end
        KIND_DELETE: begin
          if (32'(w.slot) < NumSlots) clear_slot(32'(w.slot));
        end
        default: begin
          n = 0;
          for (int s = 0; s < NumSlots && n < MaxResults; s++) begin
            if (runs_tab[s] != 8'h00) begin
              runs_out[n] = make_word(STAT_RUN, s, code_tab[s], 1'b0, 1'b0);
              n++;
              runs_tab[s] = runs_tab[s] - 8'h01;
              if (period_tab[s] == 16'h0000) clear_slot(s);
            end
          end
          any = 1'b0;
          for (int s = 0; s < NumSlots; s++) begin
            if (runs_tab[s] != 8'h00) any = 1'b1;
          end
          if (n == 0) begin
            due_results.push_back(make_word(STAT_NONE, 0, 8'h00, 1'b1, !any));
          end else begin
            runs_out[n-1].last  = 1'b1;
            runs_out[n-1].sleep = !any;
            for (int k = 0; k < n; k++) begin
              due_results.push_back(runs_out[k]);
            end
          end
        end
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 30) $display("mismatch: %s", msg);
    endtask

    task check_result(sched_out_t got);
      sched_out_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result word %h with nothing outstanding", got));
        return;
      end
      want = due_results.pop_front();
      if (got.status != want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.slot_index != want.slot_index)
        report($sformatf("slot_index %0d, want %0d", got.slot_index, want.slot_index));
      if (got.run_code != want.run_code)
        report($sformatf("run_code %h, want %h", got.run_code, want.run_code));
      if (got.last != want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
      if (got.sleep != want.sleep)
        report($sformatf("sleep %0b, want %0b", got.sleep, want.sleep));
    endtask
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  sched_in_t  in_i        = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  sched_out_t out_o;

  slot_table_model sched_model = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  bit          hold_done     = 1'b0;
  int unsigned quiet_cycles  = 0;

  always #5 clk_i = ~clk_i;

  tick_task_scheduler_core #(
    .NUM_SLOTS(NumSlots),
    .TICK_MS  (TickMs)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sched_model.check_result(out_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic sched_in_t noise_word(kind_e k);
    sched_in_t w;
    w.kind      = k;
    w.task_code = 8'($urandom);
    w.delay_ms  = 16'($urandom);
    w.period_ms = 16'($urandom);
    w.slot      = 3'($urandom);
    return w;
  endfunction

  function automatic sched_in_t add_word(bit [7:0] code, bit [15:0] dly, bit [15:0] per);
    sched_in_t w;
    w           = noise_word(KIND_ADD);
    w.task_code = code;
    w.delay_ms  = dly;
    w.period_ms = per;
    return w;
  endfunction

  function automatic sched_in_t delete_word(bit [2:0] s);
    sched_in_t w;
    w      = noise_word(KIND_DELETE);
    w.slot = s;
    return w;
  endfunction

  function automatic sched_in_t random_command();
    sched_in_t   w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      w = noise_word(KIND_TICK);
    end else if (pick < 65) begin
      w = noise_word(KIND_ADD);
      if ($urandom_range(15) == 0) w.task_code = 8'h00;
      else w.task_code = 8'($urandom_range(255, 1));
      case ($urandom_range(9))
        0: begin end
        1: w.delay_ms = 16'($urandom_range(9));
        default: w.delay_ms = 16'($urandom_range(60));
      endcase
      case ($urandom_range(9))
        0: begin end
        1: w.period_ms = 16'($urandom_range(9, 1));
        2, 3, 4: w.period_ms = 16'h0000;
        default: w.period_ms = 16'($urandom_range(80, 10));
      endcase
    end else if (pick < 75) begin
      w = noise_word(KIND_DELETE);
    end else begin
      w = noise_word(KIND_DISPATCH);
    end
    return w;
  endfunction

  task automatic send(sched_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sched_model.apply_command(w);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      send(random_command());
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sched_model.due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send(noise_word(KIND_DISPATCH));
    send(noise_word(KIND_TICK));
    send(add_word(8'hFF, 16'd0, 16'd0));
    send(add_word(8'h00, 16'd100, 16'd100));
    send(add_word(8'h01, 16'hFFFF, 16'hFFFF));
    send(add_word(8'h80, 16'd9, 16'd9));
    send(add_word(8'h55, 16'd10, 16'd10));
    send(add_word(8'hAA, 16'd20, 16'd30));
    for (int i = 0; i < 4; i++) begin
      send(add_word(8'(8'h10 + i), 16'(i * 10), 16'd20));
    end
    send(add_word(8'h77, 16'd0, 16'd0));
    for (int i = 0; i < 3; i++) begin
      send(noise_word(KIND_TICK));
    end
    send(noise_word(KIND_DISPATCH));
    send(delete_word(3'd7));
    send(delete_word(3'd0));
    send(add_word(8'h42, 16'd0, 16'd50));
    send(noise_word(KIND_TICK));
    send(noise_word(KIND_DISPATCH));
    send(noise_word(KIND_DISPATCH));
  endtask

  // one-shot task left due on every tick: run count pegs at 255, a wrap would read idle
  task automatic run_saturation();
    for (int s = 0; s < NumSlots; s++) begin
      send(delete_word(3'(s)));
    end
    send(add_word(8'h3C, 16'd0, 16'(TickMs - 1)));
    for (int i = 0; i < 256; i++) begin
      send(noise_word(KIND_TICK));
    end
    for (int i = 0; i < 2; i++) begin
      send(noise_word(KIND_DISPATCH));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 36;
    recv_idle_pct = 54;
    run_directed();
    send_random(70);
    wait_drained();

    send_idle_pct = 54;
    recv_idle_pct = 36;
    send_random(70);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    send_random(20);
    send_random(50);
    run_saturation();
    wait_drained();

    repeat (4 * NumSlots) @(posedge clk_i);
    if (sched_model.due_results.size() != 0)
      sched_model.report($sformatf("%0d result words never arrived",
                                   sched_model.due_results.size()));
    if (sched_model.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### tick_task_scheduler_core.f
rtl/tts_pkg.sv
rtl/tts_front.sv
rtl/tts_queue.sv
rtl/tts_back.sv
rtl/tick_task_scheduler_core.sv
bench/tb_tick_task_scheduler_core.sv
